// ===== rtl/mqbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mqbf_pkg
// This package holds the shared constants of the multi-queue byte FIFO: the
// operation and status codes, the register map and the reset values.
// ----------------------------------------------------------------------------
package mqbf_pkg;

	// Operation codes carried in the input tuser. Any other code acts as a query.
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Status codes carried in the output tuser.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	// Register map of the configuration channel.
	localparam int unsigned CFG_IDX_W   = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LAST  = 3'd4;

	// Queues that own registers, and the register widths.
	localparam int unsigned REG_QUEUES = 4;
	localparam int unsigned SIZE_W     = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Reset value of a size register: 64 bytes.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd6;

	// Field widths.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned QID_W   = 8;
	localparam int unsigned COUNT_W = 7;

	// Defaults of the top-level parameters.
	localparam int unsigned DEF_NUM_QUEUES      = 4;
	localparam int unsigned DEF_MAX_QUEUE_DEPTH = 64;

endpackage

// ===== rtl/multi_queue_byte_fifo.sv =====
// ----------------------------------------------------------------------------
// multi_queue_byte_fifo
// Several circular byte queues in one shared byte memory, each with its own
// power-of-two capacity, served by put, get and query requests.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on the s_ channel carries the operation in s_tuser and the
// queue id and the byte to put in s_tdata. Every request gives exactly one
// response beat on the m_ channel: the status in m_tuser, and the byte read
// with the used and free counts of that queue in m_tdata.
// Requests are taken one per cycle while no response is stalled. The
// response is valid in the cycle after its request, since the byte memory
// has a registered read port; that read register is the output register.
// Pointers and fill counts sit in flops and are updated in the cycle of the
// request, so a get right after a put to the same slot reads the freshly
// written byte from the memory. When the receiver stalls, the response is
// held and s_tready drops until the response beat is taken; s_tready is
// high when the output register is empty or being emptied in the same cycle.
// Reset empties every queue, clears the enable mask and sets all sizes to
// 64 bytes. The byte memory is not cleared. The configuration channel is
// always ready; writing a register empties the queues it concerns, and the
// user must do so only while no request is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module multi_queue_byte_fifo #(
	parameter int unsigned NUM_QUEUES      = mqbf_pkg::DEF_NUM_QUEUES,
	parameter int unsigned MAX_QUEUE_DEPTH = mqbf_pkg::DEF_MAX_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // queue_id[7:0], write_data[15:8]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	// Response channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_data[7:0], used_count[14:8],
	                               // free_count[21:15], zero[23:22]
	output logic [1:0]  m_tuser,   // status[1:0]
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mqbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mqbf_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Queues that can actually exist, and the derived widths.
	localparam int unsigned NQ    = (NUM_QUEUES < mqbf_pkg::REG_QUEUES) ?
	                                NUM_QUEUES : mqbf_pkg::REG_QUEUES;
	localparam int unsigned QIW   = (NQ > 1) ? $clog2(NQ) : 1;
	localparam int unsigned PW    = $clog2(MAX_QUEUE_DEPTH);
	localparam int unsigned CW    = PW + 1;
	localparam int unsigned DEPTH = NQ * MAX_QUEUE_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);

	// Configuration registers.
	logic [mqbf_pkg::REG_QUEUES-1:0] enable_q;
	logic [mqbf_pkg::SIZE_W-1:0]     size_q [mqbf_pkg::REG_QUEUES];

	// Per-queue pointers and fill counts.
	logic [PW-1:0] wr_ptr_q [NQ];
	logic [PW-1:0] rd_ptr_q [NQ];
	logic [CW-1:0] fill_q   [NQ];

	// Shared byte memory and its registered read data.
	logic [mqbf_pkg::BYTE_W-1:0] store_mem [DEPTH];
	logic [mqbf_pkg::BYTE_W-1:0] rd_data_q;

	// Output register fields.
	logic                         out_valid_q;
	logic [1:0]                   status_q;
	logic [mqbf_pkg::COUNT_W-1:0] used_q;
	logic [mqbf_pkg::COUNT_W-1:0] free_q;

	// Request decode.
	logic                         accept;
	logic [1:0]                   op;
	logic [mqbf_pkg::QID_W-1:0]   qid;
	logic [mqbf_pkg::BYTE_W-1:0]  wr_byte;
	logic [QIW-1:0]               qi;
	logic                         queue_ok;
	logic [mqbf_pkg::SIZE_W-1:0]  sz;
	logic [CW-1:0]                cap;
	logic [PW-1:0]                mask;
	logic [CW-1:0]                fill_cur;
	logic [PW-1:0]                wr_ptr_cur;
	logic [PW-1:0]                rd_ptr_cur;
	logic                         do_put;
	logic                         do_get;
	logic                         refused;
	logic [CW-1:0]                fill_nxt;
	logic [AW-1:0]                base_addr;
	logic [AW-1:0]                wr_addr;
	logic [AW-1:0]                rd_addr;
	logic [1:0]                   status_nxt;

	assign op      = s_tuser;
	assign qid     = s_tdata[7:0];
	assign wr_byte = s_tdata[15:8];
	assign qi      = qid[QIW-1:0];

	// The output register takes a new beat when empty or being drained.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Queue lookup, capacity and the put or get decision.
	always_comb begin
		queue_ok = (32'(qid) < NQ) && enable_q[qid[1:0]];
		sz       = size_q[qid[1:0]];
		if (32'(sz) > PW) begin
			cap = CW'(MAX_QUEUE_DEPTH);
		end else begin
			cap = CW'(1) << sz;
		end
		mask       = PW'(cap - CW'(1));
		fill_cur   = fill_q[qi];
		wr_ptr_cur = wr_ptr_q[qi];
		rd_ptr_cur = rd_ptr_q[qi];
		do_put  = 1'b0;
		do_get  = 1'b0;
		refused = 1'b0;
		case (op)
			mqbf_pkg::OP_PUT: begin
				if (fill_cur >= cap) refused = 1'b1;
				else do_put = 1'b1;
			end
			mqbf_pkg::OP_GET: begin
				if (fill_cur == '0) refused = 1'b1;
				else do_get = 1'b1;
			end
			default: begin
			end
		endcase
		do_put  = do_put && queue_ok;
		do_get  = do_get && queue_ok;
		fill_nxt = fill_cur;
		if (do_put) fill_nxt = fill_cur + CW'(1);
		if (do_get) fill_nxt = fill_cur - CW'(1);
		if (!queue_ok) status_nxt = mqbf_pkg::ST_BAD;
		else if (refused) status_nxt = mqbf_pkg::ST_REFUSED;
		else status_nxt = mqbf_pkg::ST_DONE;
		base_addr = AW'(qi) << PW;
		wr_addr   = base_addr | AW'(wr_ptr_cur & mask);
		rd_addr   = base_addr | AW'(rd_ptr_cur & mask);
	end

	// Byte memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (accept && do_put) begin
			store_mem[wr_addr] <= wr_byte;
		end
	end

	// Output register payload; the read data register is the memory output.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (do_get) rd_data_q <= store_mem[rd_addr];
			else rd_data_q <= '0;
			status_q <= status_nxt;
			if (queue_ok) begin
				used_q <= mqbf_pkg::COUNT_W'(fill_nxt);
				free_q <= mqbf_pkg::COUNT_W'(cap - fill_nxt);
			end else begin
				used_q <= '0;
				free_q <= '0;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Pointers, fill counts and configuration registers. Requests update the
	// addressed queue; a register write empties the queues it touches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			for (int i = 0; i < mqbf_pkg::REG_QUEUES; i++) begin
				size_q[i] <= mqbf_pkg::SIZE_RESET;
			end
			for (int i = 0; i < NQ; i++) begin
				wr_ptr_q[i] <= '0;
				rd_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
			end
		end else begin
			if (accept && (do_put || do_get)) begin
				fill_q[qi] <= fill_nxt;
				if (do_put) wr_ptr_q[qi] <= (wr_ptr_cur + PW'(1)) & mask;
				if (do_get) rd_ptr_q[qi] <= (rd_ptr_cur + PW'(1)) & mask;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index) inside
					mqbf_pkg::CFG_ENABLE: begin
						enable_q <= cfg_data[mqbf_pkg::REG_QUEUES-1:0];
						for (int i = 0; i < NQ; i++) begin
							if (cfg_data[i] != enable_q[i]) begin
								wr_ptr_q[i] <= '0;
								rd_ptr_q[i] <= '0;
								fill_q[i]   <= '0;
							end
						end
					end
					[mqbf_pkg::CFG_SIZE_FIRST:mqbf_pkg::CFG_SIZE_LAST]: begin
						size_q[2'(cfg_index - mqbf_pkg::CFG_SIZE_FIRST)] <=
							cfg_data[mqbf_pkg::SIZE_W-1:0];
						for (int i = 0; i < NQ; i++) begin
							if (32'(cfg_index - mqbf_pkg::CFG_SIZE_FIRST) == i) begin
								wr_ptr_q[i] <= '0;
								rd_ptr_q[i] <= '0;
								fill_q[i]   <= '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Response beat.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, free_q, used_q, rd_data_q};

	// The addressed queue never holds more than its capacity.
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && queue_ok |-> fill_cur <= cap)
		else $error("fill count exceeds queue capacity");

	// Pointer distance agrees with the stored fill count.
	a_ptr_matches_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && queue_ok |->
		((wr_ptr_cur - rd_ptr_cur) & mask) == (PW'(fill_cur) & mask))
		else $error("pointers disagree with fill count");

	// A request to a missing queue answers with a bad status and zero fields.
	a_bad_queue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !queue_ok |=> m_tuser == mqbf_pkg::ST_BAD && m_tdata == '0)
		else $error("bad queue response carries data");

	// A stalled response blocks new requests.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while response is stalled");

	// A successful put raises the used count by one.
	a_put_counts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_put |=>
		m_tdata[14:8] == mqbf_pkg::COUNT_W'($past(fill_cur) + CW'(1)))
		else $error("put did not advance used count");

endmodule
